// File: design/icmr_pkg.sv
// Package: shared constants and storage types of the inclusive cache with MIN replacement.
package icmr_pkg;

  localparam int L2_SETS    = 1024;
  localparam int L2_WAYS    = 8;
  localparam int L3_WAYS    = 1024;
  localparam int STAMP_BITS = 32;

  localparam int BLOCK_W     = 58;
  localparam int IN_STAMP_W  = 32;
  localparam int WAY_FIELD_W = 10;

  localparam int L2_SET_W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int L2_WAY_W = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int AGE_W    = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int L3_IDX_W = $clog2(L3_WAYS);
  localparam int CLR_DEPTH = (L2_SETS > L3_WAYS) ? L2_SETS : L3_WAYS;
  localparam int CNT_W    = $clog2(CLR_DEPTH) + 1;

  // one L2 way: valid bit and block number
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] tag;
  } l2_way_t;

  // one L2 set: all ways plus their LRU ranks
  typedef struct packed {
    l2_way_t [L2_WAYS-1:0]          way;
    logic [L2_WAYS-1:0][AGE_W-1:0]  age;
  } l2_row_t;

  // one L3 way: tag and next-use information
  typedef struct packed {
    logic                  valid;
    logic [BLOCK_W-1:0]    tag;
    logic                  has_next;
    logic [STAMP_BITS-1:0] stamp;
  } l3_entry_t;

endpackage

// File: design/icmr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module icmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/inclusive_cache_min_replacement_unit.sv
// Inclusive two-level cache with MIN replacement: one request at a time. After reset the unit
// clears both tag memories and holds in_stall high. A counted request then scans the fully
// associative L3 one way per cycle through its single read port to find a hit and the MIN
// victim, followed by the L3 write, an optional L2 back-invalidate read-modify-write and the
// L2 lookup and update, which waits while the output is stalled.
// A request with access_counts low is accepted in the idle state and gives no result. A new request is
// taken while a finished result still waits at the output.
module inclusive_cache_min_replacement_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          access_counts,
  input  logic [icmr_pkg::BLOCK_W-1:0]  block_address,
  input  logic                          has_next_use,
  input  logic [icmr_pkg::IN_STAMP_W-1:0] next_use_stamp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          l2_hit,
  output logic                          l3_hit,
  output logic                          l3_evicted,
  output logic [icmr_pkg::BLOCK_W-1:0]  evicted_block,
  output logic                          back_invalidated,
  output logic [icmr_pkg::WAY_FIELD_W-1:0] l3_way
);
  import icmr_pkg::*;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_BI    = 3'd4;
  localparam logic [2:0] S_OWNRD = 3'd5;
  localparam logic [2:0] S_OWNUP = 3'd6;

  logic [2:0] state;
  logic [CNT_W-1:0] cnt;

  // request registers
  logic [BLOCK_W-1:0]    blk;
  logic                  hasnext;
  logic [STAMP_BITS-1:0] stamp;

  // scan pipeline and trackers
  logic                  rd_v;
  logic [L3_IDX_W-1:0]   rd_idx;
  logic                  match_f, inv_f, nn_f, max_f;
  logic [L3_IDX_W-1:0]   match_w, inv_w, nn_w, max_w;
  logic [BLOCK_W-1:0]    nn_tag, max_tag;
  logic [STAMP_BITS-1:0] max_val;

  // decision results
  logic                  res_l3hit, res_ev, res_bi;
  logic [BLOCK_W-1:0]    res_evtag;
  logic [L3_IDX_W-1:0]   res_l3w;

  // memory ports
  logic                l3_we;
  logic [L3_IDX_W-1:0] l3_waddr, l3_raddr;
  l3_entry_t           l3_wdata, l3_rdata;
  logic                l2_we;
  logic [L2_SET_W-1:0] l2_waddr, l2_raddr;
  l2_row_t             l2_wdata, l2_rdata;

  icmr_ram #(.WIDTH($bits(l3_entry_t)), .DEPTH(L3_WAYS)) u_l3_ram (
    .clk(clk), .we(l3_we), .waddr(l3_waddr), .wdata(l3_wdata),
    .raddr(l3_raddr), .rdata(l3_rdata)
  );

  icmr_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(L2_SETS)) u_l2_ram (
    .clk(clk), .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata),
    .raddr(l2_raddr), .rdata(l2_rdata)
  );

  // L3 victim choice after the scan
  logic                dec_ev;
  logic [BLOCK_W-1:0]  dec_evtag;
  logic [L3_IDX_W-1:0] dec_l3w;
  always_comb begin
    dec_ev    = !match_f && !inv_f;
    dec_evtag = nn_f ? nn_tag : max_tag;
    priority if (match_f) dec_l3w = match_w;
    else if (inv_f)       dec_l3w = inv_w;
    else if (nn_f)        dec_l3w = nn_w;
    else                  dec_l3w = max_w;
  end

  logic [L2_SET_W-1:0] own_set, ev_set;
  assign own_set = blk[L2_SET_W-1:0];
  assign ev_set  = dec_evtag[L2_SET_W-1:0];

  // back-invalidate of the L3 victim in its L2 set
  l2_row_t bi_row;
  logic    bi_hit;
  always_comb begin
    bi_row = l2_rdata;
    bi_hit = 1'b0;
    for (int j = 0; j < L2_WAYS; j++) begin
      if (l2_rdata.way[j].valid && l2_rdata.way[j].tag == res_evtag) begin
        bi_row.way[j].valid = 1'b0;
        bi_hit = 1'b1;
      end
    end
  end

  // L2 lookup, fill choice and LRU update of the own set
  l2_row_t             up_row;
  logic                own_hit, inv_found;
  logic [L2_WAY_W-1:0] hit_w, inv_sel, lru_w, w2;
  logic [AGE_W-1:0]    max_age, old_age;
  always_comb begin
    own_hit   = 1'b0;
    hit_w     = '0;
    inv_found = 1'b0;
    inv_sel   = '0;
    lru_w     = '0;
    max_age   = '0;
    for (int j = 0; j < L2_WAYS; j++) begin
      if (!own_hit && l2_rdata.way[j].valid && l2_rdata.way[j].tag == blk) begin
        own_hit = 1'b1;
        hit_w   = L2_WAY_W'(j);
      end
      if (!inv_found && !l2_rdata.way[j].valid) begin
        inv_found = 1'b1;
        inv_sel   = L2_WAY_W'(j);
      end
      if (l2_rdata.age[j] >= max_age) begin
        max_age = l2_rdata.age[j];
        lru_w   = L2_WAY_W'(j);
      end
    end
    priority if (own_hit) w2 = hit_w;
    else if (inv_found)   w2 = inv_sel;
    else                  w2 = lru_w;
    up_row  = l2_rdata;
    old_age = l2_rdata.age[w2];
    for (int j = 0; j < L2_WAYS; j++) begin
      if (L2_WAY_W'(j) != w2 && l2_rdata.age[j] <= old_age &&
          l2_rdata.age[j] < AGE_W'(L2_WAYS - 1)) begin
        up_row.age[j] = l2_rdata.age[j] + AGE_W'(1);
      end
    end
    up_row.age[w2]       = '0;
    up_row.way[w2].valid = 1'b1;
    up_row.way[w2].tag   = blk;
  end

  logic out_busy;
  assign out_busy = out_valid && out_stall;
  assign in_stall = (state != S_IDLE);

  // memory control
  always_comb begin
    l3_we    = 1'b0;
    l3_waddr = dec_l3w;
    l3_wdata = '{valid: 1'b1, tag: blk, has_next: hasnext, stamp: stamp};
    l3_raddr = cnt[L3_IDX_W-1:0];
    l2_we    = 1'b0;
    l2_waddr = own_set;
    l2_wdata = up_row;
    l2_raddr = own_set;
    unique case (state)
      S_CLR: begin
        l3_we    = (cnt < CNT_W'(L3_WAYS));
        l3_waddr = cnt[L3_IDX_W-1:0];
        l3_wdata = '0;
        l2_we    = (cnt < CNT_W'(L2_SETS));
        l2_waddr = cnt[L2_SET_W-1:0];
        l2_wdata = '0;
      end
      S_DEC: begin
        l3_we    = 1'b1;
        l2_raddr = dec_ev ? ev_set : own_set;
      end
      S_BI: begin
        l2_we    = 1'b1;
        l2_waddr = res_evtag[L2_SET_W-1:0];
        l2_wdata = bi_row;
      end
      S_OWNUP: begin
        l2_we = !out_busy;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OWNUP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (cnt == CNT_W'(CLR_DEPTH - 1)) begin
            state <= S_IDLE;
          end
          cnt <= cnt + CNT_W'(1);
        end
        S_IDLE: begin
          if (in_valid && access_counts) begin
            blk     <= block_address;
            hasnext <= has_next_use;
            stamp   <= next_use_stamp[STAMP_BITS-1:0];
            match_f <= 1'b0;
            inv_f   <= 1'b0;
            nn_f    <= 1'b0;
            max_f   <= 1'b0;
            cnt     <= '0;
            rd_v    <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_v   <= (cnt < CNT_W'(L3_WAYS));
          rd_idx <= cnt[L3_IDX_W-1:0];
          if (cnt < CNT_W'(L3_WAYS)) begin
            cnt <= cnt + CNT_W'(1);
          end else if (!rd_v) begin
            state <= S_DEC;
          end
          if (rd_v) begin
            if (!match_f && l3_rdata.valid && l3_rdata.tag == blk) begin
              match_f <= 1'b1;
              match_w <= rd_idx;
            end
            if (!inv_f && !l3_rdata.valid) begin
              inv_f <= 1'b1;
              inv_w <= rd_idx;
            end
            if (!nn_f && l3_rdata.valid && !l3_rdata.has_next) begin
              nn_f   <= 1'b1;
              nn_w   <= rd_idx;
              nn_tag <= l3_rdata.tag;
            end
            if (l3_rdata.valid && (!max_f || l3_rdata.stamp >= max_val)) begin
              max_f   <= 1'b1;
              max_w   <= rd_idx;
              max_val <= l3_rdata.stamp;
              max_tag <= l3_rdata.tag;
            end
          end
        end
        S_DEC: begin
          res_l3hit <= match_f;
          res_ev    <= dec_ev;
          res_evtag <= dec_evtag;
          res_l3w   <= dec_l3w;
          res_bi    <= 1'b0;
          state     <= dec_ev ? S_BI : S_OWNUP;
        end
        S_BI: begin
          res_bi <= bi_hit;
          state  <= S_OWNRD;
        end
        S_OWNRD: begin
          state <= S_OWNUP;
        end
        S_OWNUP: begin
          if (!out_busy) begin
            out_valid        <= 1'b1;
            l2_hit           <= own_hit;
            l3_hit           <= res_l3hit;
            l3_evicted       <= res_ev;
            evicted_block    <= res_ev ? res_evtag : '0;
            back_invalidated <= res_bi;
            l3_way           <= WAY_FIELD_W'(res_l3w);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/icmr_checker.sv
// Port-level checker for the cache unit, bound to the top level.
module icmr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          l2_hit,
  input logic                          l3_hit,
  input logic                          l3_evicted,
  input logic [icmr_pkg::BLOCK_W-1:0]  evicted_block,
  input logic                          back_invalidated,
  input logic [icmr_pkg::WAY_FIELD_W-1:0] l3_way
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its way and its eviction flag
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(l3_way) && $stable(l3_evicted))
    else $error("stalled result changed");

  // inclusion: an L2 hit is an L3 hit
  a_incl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!l2_hit || l3_hit))
    else $error("L2 hit without L3 hit");

  // an L3 hit never evicts
  a_hit_noev: assert property (@(posedge clk) disable iff (rst)
    out_valid && l3_hit |-> !l3_evicted)
    else $error("eviction on L3 hit");

  // no eviction means no victim fields
  a_noev: assert property (@(posedge clk) disable iff (rst)
    out_valid && !l3_evicted |-> (evicted_block == '0) && !back_invalidated)
    else $error("victim fields set without eviction");

endmodule

bind inclusive_cache_min_replacement_unit icmr_checker u_icmr_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .l2_hit(l2_hit), .l3_hit(l3_hit), .l3_evicted(l3_evicted),
  .evicted_block(evicted_block), .back_invalidated(back_invalidated), .l3_way(l3_way)
);
